// ===== rtl/pptsc_pkg.sv =====
`timescale 1ns / 1ps
package pptsc_pkg;

   localparam int TilePixels     = 16;
   localparam int MaxRingColumns = 32;

   localparam int RingW   = 6;
   localparam int StepW   = 4;
   localparam int CameraW = 8;
   localparam int DelayW  = 8;
   localparam int PhaseW  = 4;
   localparam int SlotW   = 5;
   localparam int CsrIdxW = 2;
   localparam int CsrDatW = 8;

   localparam logic [CsrIdxW-1:0] CsrRingColumns  = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrPixelStep    = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrMaxCamera    = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrDelayFrames  = 2'd3;

   localparam logic [RingW-1:0]   RingColumnsRst  = 6'd12;
   localparam logic [StepW-1:0]   PixelStepRst    = 4'd2;
   localparam logic [CameraW-1:0] MaxCameraRst    = 8'd212;
   localparam logic [DelayW-1:0]  DelayFramesRst  = 8'd2;

   typedef struct packed {
      logic [RingW-1:0]   ring_columns;
      logic [StepW-1:0]   pixel_step;
      logic [CameraW-1:0] max_camera_tile;
      logic [DelayW-1:0]  delay_frames;
   } cfg_type;

   typedef struct packed {
      logic               load_request;
      logic [SlotW-1:0]   load_slot;
      logic [CameraW-1:0] load_world_column;
      logic [CameraW-1:0] camera_tile;
      logic [PhaseW-1:0]  phase_out;
      logic [SlotW-1:0]   head_out;
      logic               position_update;
      logic               moving_right;
   } result_type;

endpackage

// ===== rtl/ping_pong_tile_scroll_controller_core.sv =====
`timescale 1ns / 1ps
// Tile column ring scroller. Each frame tick beat yields exactly one result beat
// holding the camera tile, pixel phase, ring head, direction and any column load
// request. A beat passes through the input register, then the result register; the
// single state update between them lets a new tick in every cycle unless rsp_stall
// holds back a full pipeline. Registers are written through the csr port, which is
// always ready; the user must write them only while no beat is in flight (not enforced).
module ping_pong_tile_scroll_controller_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_frame_tick,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_load_request,
   output logic [4:0]                    rsp_load_slot,
   output logic [7:0]                    rsp_load_world_column,
   output logic [7:0]                    rsp_camera_tile,
   output logic [3:0]                    rsp_phase_out,
   output logic [4:0]                    rsp_head_out,
   output logic                          rsp_position_update,
   output logic                          rsp_moving_right,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pptsc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pptsc_pkg::CsrDatW-1:0] csr_data
);
   import pptsc_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type out_ff;
   logic       in_valid_ff;
   logic       in_tick_ff;
   logic       out_valid_ff;
   logic       out_adv;
   logic       in_adv;

   assign csr_ready = 1'b1;
   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign in_adv    = !in_valid_ff || out_adv;
   assign req_stall = !in_adv;

   pptsc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   pptsc_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (in_valid_ff && out_adv),
      .tick   (in_tick_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_adv) begin
            in_valid_ff <= req_valid;
         end
         if (out_adv) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_valid) begin
         in_tick_ff <= req_frame_tick;
      end
      if (out_adv && in_valid_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_load_request      = out_ff.load_request;
   assign rsp_load_slot         = out_ff.load_slot;
   assign rsp_load_world_column = out_ff.load_world_column;
   assign rsp_camera_tile       = out_ff.camera_tile;
   assign rsp_phase_out         = out_ff.phase_out;
   assign rsp_head_out          = out_ff.head_out;
   assign rsp_position_update   = out_ff.position_update;
   assign rsp_moving_right      = out_ff.moving_right;

endmodule

// ===== rtl/pptsc_csr.sv =====
`timescale 1ns / 1ps
module pptsc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [pptsc_pkg::CsrIdxW-1:0] wr_index,
   input  logic [pptsc_pkg::CsrDatW-1:0] wr_data,
   output pptsc_pkg::cfg_type            cfg
);
   import pptsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CsrRingColumns: cfg_in.ring_columns    = wr_data[RingW-1:0];
            CsrPixelStep:   cfg_in.pixel_step      = wr_data[StepW-1:0];
            CsrMaxCamera:   cfg_in.max_camera_tile = wr_data[CameraW-1:0];
            CsrDelayFrames: cfg_in.delay_frames    = wr_data[DelayW-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_columns    <= RingColumnsRst;
         cfg_ff.pixel_step      <= PixelStepRst;
         cfg_ff.max_camera_tile <= MaxCameraRst;
         cfg_ff.delay_frames    <= DelayFramesRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/pptsc_step.sv =====
`timescale 1ns / 1ps
module pptsc_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  tick,
   input  pptsc_pkg::cfg_type    cfg,
   output pptsc_pkg::result_type result
);
   import pptsc_pkg::*;

   logic [CameraW-1:0] camera_ff, camera_in;
   logic [PhaseW-1:0]  phase_ff, phase_in;
   logic [SlotW-1:0]   head_ff, head_in;
   logic               right_ff, right_in;
   logic [DelayW-1:0]  delay_ff, delay_in;

   logic [RingW-1:0]   ring_n;
   logic [RingW-1:0]   head_inc;
   logic [PhaseW:0]    phase_sum;
   logic               req;
   logic [SlotW-1:0]   slot;
   logic [CameraW-1:0] wcol;
   logic               upd;

   always_comb begin
      if (cfg.ring_columns == '0) begin
         ring_n = RingW'(1);
      end else if (cfg.ring_columns > RingW'(MaxRingColumns)) begin
         ring_n = RingW'(MaxRingColumns);
      end else begin
         ring_n = cfg.ring_columns;
      end
   end

   always_comb begin
      camera_in = camera_ff;
      phase_in  = phase_ff;
      head_in   = head_ff;
      right_in  = right_ff;
      delay_in  = delay_ff;
      req       = 1'b0;
      slot      = '0;
      wcol      = '0;
      upd       = 1'b0;
      head_inc  = {1'b0, head_ff} + RingW'(1);
      phase_sum = {1'b0, phase_ff} + {1'b0, cfg.pixel_step};
      if (tick) begin
         if (delay_ff != '0) begin
            delay_in = delay_ff - DelayW'(1);
         end else begin
            delay_in = cfg.delay_frames;
            upd      = 1'b1;
            if (right_ff) begin
               if (camera_ff >= cfg.max_camera_tile && phase_ff == '0) begin
                  right_in = 1'b0;
               end else if (phase_sum >= (PhaseW+1)'(TilePixels)) begin
                  phase_in  = '0;
                  camera_in = camera_ff + CameraW'(1);
                  head_in   = (head_inc >= ring_n) ? '0 : head_inc[SlotW-1:0];
                  slot      = (head_in == '0) ? SlotW'(ring_n - RingW'(1))
                                              : head_in - SlotW'(1);
                  wcol      = camera_in + CameraW'(ring_n) - CameraW'(1);
                  req       = 1'b1;
               end else begin
                  phase_in = phase_sum[PhaseW-1:0];
               end
            end else begin
               if (camera_ff == '0 && phase_ff == '0) begin
                  right_in = 1'b1;
               end else if (phase_ff == '0) begin
                  camera_in = camera_ff - CameraW'(1);
                  if (head_ff == '0 || {1'b0, head_ff} >= ring_n) begin
                     head_in = SlotW'(ring_n - RingW'(1));
                  end else begin
                     head_in = head_ff - SlotW'(1);
                  end
                  slot     = head_in;
                  wcol     = camera_in;
                  req      = 1'b1;
                  phase_in = (cfg.pixel_step != '0)
                           ? PhaseW'((PhaseW+1)'(TilePixels) - {1'b0, cfg.pixel_step})
                           : '0;
               end else begin
                  phase_in = (cfg.pixel_step > phase_ff) ? '0
                                                         : phase_ff - cfg.pixel_step;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_ff <= '0;
         phase_ff  <= '0;
         head_ff   <= '0;
         right_ff  <= 1'b1;
         delay_ff  <= DelayFramesRst;
      end else if (fire) begin
         camera_ff <= camera_in;
         phase_ff  <= phase_in;
         head_ff   <= head_in;
         right_ff  <= right_in;
         delay_ff  <= delay_in;
      end
   end

   always_comb begin
      result.load_request      = req;
      result.load_slot         = slot;
      result.load_world_column = wcol;
      result.camera_tile       = camera_in;
      result.phase_out         = phase_in;
      result.head_out          = head_in;
      result.position_update   = upd;
      result.moving_right      = right_in;
   end

endmodule

// ===== rtl/pptsc_checker.sv =====
`timescale 1ns / 1ps
module pptsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_load_request,
   input logic [4:0] rsp_load_slot,
   input logic [7:0] rsp_load_world_column,
   input logic [7:0] rsp_camera_tile,
   input logic [3:0] rsp_phase_out,
   input logic [4:0] rsp_head_out,
   input logic       rsp_position_update,
   input logic       rsp_moving_right
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_camera_tile)
         && $stable(rsp_head_out) && $stable(rsp_phase_out))
      else $error("result beat changed while stalled");

   a_load_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_request |-> rsp_position_update)
      else $error("column load on an idle frame");

   a_no_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_load_request |-> rsp_load_slot == '0
         && rsp_load_world_column == '0)
      else $error("load fields set without a load request");

   a_right_load_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_request && rsp_moving_right |-> rsp_phase_out == '0)
      else $error("right load with nonzero phase");

endmodule

bind ping_pong_tile_scroll_controller_core pptsc_checker u_pptsc_checker (.*);

// ===== dv/tb_ping_pong_tile_scroll_controller_core.sv =====
`timescale 1ns / 1ps
module tb_ping_pong_tile_scroll_controller_core;
   import pptsc_pkg::*;

   localparam int CycleLimit = 600000;
   localparam int LongHold   = 120;

   class scroll_tracker;
      cfg_type    regs;
      int         camera;
      int         phase;
      int         head;
      int         delay_left;
      bit         heading_right;
      result_type due_frames[$];
      int         errors;

      function new();
         regs.ring_columns    = RingColumnsRst;
         regs.pixel_step      = PixelStepRst;
         regs.max_camera_tile = MaxCameraRst;
         regs.delay_frames    = DelayFramesRst;
         camera        = 0;
         phase         = 0;
         head          = 0;
         delay_left    = int'(DelayFramesRst);
         heading_right = 1'b1;
         errors        = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDatW-1:0] val);
         case (idx)
            CsrRingColumns: regs.ring_columns    = val[RingW-1:0];
            CsrPixelStep:   regs.pixel_step      = val[StepW-1:0];
            CsrMaxCamera:   regs.max_camera_tile = val[CameraW-1:0];
            CsrDelayFrames: regs.delay_frames    = val[DelayW-1:0];
            default: ;
         endcase
      endfunction

      function void take_tick(bit tick);
         result_type r;
         int         n;
         int         step;
         int         slot;
         int         wcol;
         bit         load;
         bit         upd;
         slot = 0;
         wcol = 0;
         load = 1'b0;
         upd  = 1'b0;
         step = int'(regs.pixel_step);
         n    = int'(regs.ring_columns);
         if (n == 0) n = 1;
         if (n > MaxRingColumns) n = MaxRingColumns;
         if (tick) begin
            if (delay_left > 0) begin
               delay_left--;
            end else begin
               delay_left = int'(regs.delay_frames);
               upd = 1'b1;
               if (heading_right) begin
                  if (camera >= int'(regs.max_camera_tile) && phase == 0) begin
                     heading_right = 1'b0;
                  end else begin
                     phase += step;
                     if (phase >= TilePixels) begin
                        phase  = 0;
                        camera = (camera + 1) & 255;
                        head   = (head >= n) ? 0 : head + 1;
                        if (head >= n) head = 0;
                        slot = head + n - 1;
                        if (slot >= n) slot -= n;
                        wcol = (camera + n - 1) & 255;
                        load = 1'b1;
                     end
                  end
               end else if (camera == 0 && phase == 0) begin
                  heading_right = 1'b1;
               end else if (phase == 0) begin
                  camera = (camera - 1) & 255;
                  head   = (head == 0 || head >= n) ? n - 1 : head - 1;
                  slot   = head;
                  wcol   = camera;
                  load   = 1'b1;
                  phase  = (step > 0 && step < TilePixels) ? TilePixels - step : 0;
               end else begin
                  phase = (step > phase) ? 0 : phase - step;
               end
            end
         end
         r.load_request      = load;
         r.load_slot         = SlotW'(slot);
         r.load_world_column = CameraW'(wcol);
         r.camera_tile       = CameraW'(camera);
         r.phase_out         = PhaseW'(phase);
         r.head_out          = SlotW'(head);
         r.position_update   = upd;
         r.moving_right      = heading_right;
         due_frames.push_back(r);
      endfunction

      function string show(result_type r);
         return $sformatf("req=%0d slot=%0d wcol=%0d cam=%0d phase=%0d head=%0d upd=%0d right=%0d",
                          r.load_request, r.load_slot, r.load_world_column, r.camera_tile,
                          r.phase_out, r.head_out, r.position_update, r.moving_right);
      endfunction

      function void flag(string what, string want, result_type got);
         errors++;
         if (errors <= 10)
            $display("%0t: %s: expected {%s} got {%s}", $time, what, want, show(got));
      endfunction

      function void match_beat(result_type got);
         result_type want;
         string      bad;
         bad = "";
         if (due_frames.size() == 0) begin
            flag("unexpected beat", "nothing", got);
            return;
         end
         want = due_frames.pop_front();
         if (got.load_request !== want.load_request) bad = {bad, " load_request"};
         if (got.load_slot !== want.load_slot) bad = {bad, " load_slot"};
         if (got.load_world_column !== want.load_world_column) bad = {bad, " load_world_column"};
         if (got.camera_tile !== want.camera_tile) bad = {bad, " camera_tile"};
         if (got.phase_out !== want.phase_out) bad = {bad, " phase_out"};
         if (got.head_out !== want.head_out) bad = {bad, " head_out"};
         if (got.position_update !== want.position_update) bad = {bad, " position_update"};
         if (got.moving_right !== want.moving_right) bad = {bad, " moving_right"};
         if (bad != "") flag({"mismatch in", bad}, show(want), got);
      endfunction
   endclass

   logic                 clock;
   logic                 reset                 = 1'b1;
   logic                 req_valid             = 1'b0;
   logic                 req_stall;
   logic                 req_frame_tick        = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall             = 1'b0;
   logic                 rsp_load_request;
   logic [4:0]           rsp_load_slot;
   logic [7:0]           rsp_load_world_column;
   logic [7:0]           rsp_camera_tile;
   logic [3:0]           rsp_phase_out;
   logic [4:0]           rsp_head_out;
   logic                 rsp_position_update;
   logic                 rsp_moving_right;
   logic                 csr_valid             = 1'b0;
   logic                 csr_ready;
   logic [CsrIdxW-1:0]   csr_index             = CsrRingColumns;
   logic [CsrDatW-1:0]   csr_data              = '0;

   bit                   idle_on               = 1'b1;
   bit                   long_hold             = 1'b0;
   scroll_tracker        tracker               = new();

   ping_pong_tile_scroll_controller_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_frame_tick        (req_frame_tick),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_load_request      (rsp_load_request),
      .rsp_load_slot         (rsp_load_slot),
      .rsp_load_world_column (rsp_load_world_column),
      .rsp_camera_tile       (rsp_camera_tile),
      .rsp_phase_out         (rsp_phase_out),
      .rsp_head_out          (rsp_head_out),
      .rsp_position_update   (rsp_position_update),
      .rsp_moving_right      (rsp_moving_right),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic send_tick(input bit tick);
      req_valid      <= 1'b1;
      req_frame_tick <= tick;
      do @(posedge clock); while (req_stall);
      tracker.take_tick(tick);
      if (idle_on && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic run_ticks(input int count);
      for (int i = 0; i < count; i++) send_tick($urandom_range(0, 9) != 0);
   endtask

   // hold until every frame has come back out
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.due_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDatW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, val);
   endtask

   task automatic apply_settings(input logic [CsrDatW-1:0] ring, input logic [CsrDatW-1:0] step,
                                 input logic [CsrDatW-1:0] max_cam,
                                 input logic [CsrDatW-1:0] delay);
      drain();
      write_csr(CsrRingColumns, ring);
      write_csr(CsrPixelStep, step);
      write_csr(CsrMaxCamera, max_cam);
      write_csr(CsrDelayFrames, delay);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int         stall_left;
      int         hold_left;
      result_type got;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.load_request      = rsp_load_request;
            got.load_slot         = rsp_load_slot;
            got.load_world_column = rsp_load_world_column;
            got.camera_tile       = rsp_camera_tile;
            got.phase_out         = rsp_phase_out;
            got.head_out          = rsp_head_out;
            got.position_update   = rsp_position_update;
            got.moving_right      = rsp_moving_right;
            tracker.match_beat(got);
         end
         if (long_hold) begin
            hold_left = LongHold;
            long_hold = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles <= CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_ping_pong_tile_scroll_controller_core: errors");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no tick, two skipped ticks, then the first active frame
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);

      // tile wrap, turn at the right edge, step left into a new tile,
      // oversized step clamped to zero, turn at tile zero
      apply_settings(8'd3, 8'd15, 8'd1, 8'd0);
      for (int i = 0; i < 14; i++) send_tick(i != 7);

      apply_settings(8'd1, 8'd15, 8'd0, 8'd0);
      run_ticks(60);
      apply_settings(8'd32, 8'd1, 8'd3, 8'd0);
      run_ticks(150);
      // zero ring size and a step masked to zero
      apply_settings(8'd64, 8'hF0, 8'd4, 8'd0);
      run_ticks(30);
      apply_settings(8'd63, 8'd7, 8'd255, 8'd255);
      run_ticks(40);

      // long run to the far edge with the world column wrapping
      apply_settings(8'd45, 8'd15, 8'd255, 8'd0);
      run_ticks(100);
      long_hold = 1'b1;
      run_ticks(200);
      drain();
      run_ticks(300);

      for (int p = 0; p < 7; p++) begin
         if (p == 5) idle_on = 1'b0;
         apply_settings(CsrDatW'($urandom_range(0, 255)), CsrDatW'($urandom_range(0, 255)),
                        CsrDatW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 8)),
                        CsrDatW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 3)));
         run_ticks(40);
      end

      drain();
      repeat (6) @(posedge clock);
      if (tracker.errors == 0)
         $display("tb_ping_pong_tile_scroll_controller_core: clean");
      else
         $display("tb_ping_pong_tile_scroll_controller_core: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pptsc_pkg.sv
rtl/pptsc_csr.sv
rtl/pptsc_step.sv
rtl/ping_pong_tile_scroll_controller_core.sv
rtl/pptsc_checker.sv
dv/tb_ping_pong_tile_scroll_controller_core.sv
